// File: hw/rtl/frue_pkg.sv
// shared types, constants and byte-order helpers for the flow record update engine
// no dependencies
`default_nettype none

package frue_pkg;

  localparam int SLOT_BITS   = 12;
  localparam int SLOTS       = 1 << SLOT_BITS;
  localparam int HASH_BITS   = 48;
  localparam int MOD_BITS    = 24;
  localparam int MOD_STEPS   = 4;
  localparam int DIV_STEPS   = 64;
  localparam int CNT_BITS    = 12;

  localparam logic [HASH_BITS-1:0] HASH_SEED = HASH_BITS'(5381);
  localparam logic [MOD_BITS-1:0]  HASH_MOD  = MOD_BITS'(10485750);
  // floor(2^48 / HASH_MOD)
  localparam logic [24:0]          HASH_RECIP = 25'd26843571;
  localparam logic [31:0]          KIND_END  = 32'd4;
  localparam logic [29:0]          NS_PER_S  = 30'd1000000000;
  localparam logic [63:0]          INTERVAL_RESET = 64'd1000000000;
  localparam logic [16:0]          LOSS_ONE  = 17'h10000;

  localparam logic [1:0] ST_STALE   = 2'd0;
  localparam logic [1:0] ST_CREATED = 2'd1;
  localparam logic [1:0] ST_UPDATED = 2'd2;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [63:0] stamp_ns;
    logic [63:0] byte_rows_low;
    logic [63:0] byte_rows_high;
    logic [63:0] packet_rows;
    logic [31:0] ack_number;
    logic [31:0] packet_kind;
  } rec_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] slot_index;
    logic [31:0] total_bytes;
    logic [31:0] total_packets;
    logic        report_valid;
    logic [63:0] throughput_bps;
    logic [16:0] loss_fraction;
    logic        ended;
    logic [63:0] duration_ns;
  } res_t;

  typedef struct packed {
    logic        used;
    logic [63:0] key;
    logic [31:0] ports;
    logic [63:0] start_ns;
    logic [63:0] last_ns;
    logic [63:0] report_ns;
    logic [31:0] last_byte_min;
    logic [15:0] last_packet_min;
    logic [31:0] last_ack;
    logic [31:0] total_bytes;
    logic [31:0] total_packets;
    logic [31:0] reported_bytes;
    logic [31:0] retransmits;
    logic [31:0] interval_packets;
  } slot_t;

  typedef struct packed {
    logic                load;
    logic                hash_step;
    logic                mod_step;
    logic                clear_wr;
    logic                rd;
    logic                upd;
    logic                mul;
    logic                bps_init;
    logic                loss_init;
    logic                div_step;
    logic                bps_save;
    logic                loss_save;
    logic                out_load;
    logic [CNT_BITS-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic report;
    logic full;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [15:0] swap16(input logic [15:0] x);
    return {x[7:0], x[15:8]};
  endfunction

  function automatic logic [63:0] swap64(input logic [63:0] x);
    return {swap32(x[31:0]), swap32(x[63:32])};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/frue_ctrl.sv
// controller state machine of the flow record update engine
// depends on frue_pkg; drives commands into frue_dp
`default_nettype none

module frue_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire frue_pkg::sts_t sts,
  output frue_pkg::cmd_t     cmd
);
  import frue_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_HASH  = 13'b0000000000100,
    S_MOD   = 13'b0000000001000,
    S_READ  = 13'b0000000010000,
    S_UPD   = 13'b0000000100000,
    S_MUL   = 13'b0000001000000,
    S_BINIT = 13'b0000010000000,
    S_BPS   = 13'b0000100000000,
    S_LINIT = 13'b0001000000000,
    S_LOSS  = 13'b0010000000000,
    S_LSAVE = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t              state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cnt    = cnt;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_BITS'(SLOTS - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          cnt_next   = '0;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == CNT_BITS'(3)) begin
          cnt_next   = '0;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_BITS'(MOD_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sts.report ? S_BINIT : S_DONE;
      end
      S_BINIT: begin
        cmd.bps_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_BPS;
      end
      S_BPS: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_BITS'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_LINIT;
        end
      end
      S_LINIT: begin
        cmd.bps_save = 1'b1;
        if (sts.full) begin
          state_next = S_LSAVE;
        end else begin
          cmd.loss_init = 1'b1;
          cnt_next      = '0;
          state_next    = S_LOSS;
        end
      end
      S_LOSS: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_BITS'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_LSAVE;
        end
      end
      S_LSAVE: begin
        cmd.loss_save = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
        cnt_next   = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/frue_dp.sv
// datapath of the flow record update engine: hash, slot memory, update, divider
// depends on frue_pkg; commanded by frue_ctrl
`default_nettype none

module frue_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire frue_pkg::rec_t rec,
  input  wire logic           cfg_valid,
  input  wire logic [63:0]    cfg_data,
  input  wire frue_pkg::cmd_t cmd,
  output frue_pkg::sts_t      sts,
  input  wire logic           out_ready,
  output logic                out_valid,
  output frue_pkg::res_t      res
);
  import frue_pkg::*;

  slot_t mem [SLOTS];

  logic [63:0]          interval;
  rec_t                 rec_q;
  logic [HASH_BITS-1:0] h;
  logic [MOD_BITS-1:0]  rem_h;
  slot_t                rd_q;
  logic [SLOT_BITS-1:0] idx;

  logic [1:0]  st_q;
  logic [31:0] tb_q, tp_q;
  logic        rep_q, end_q, full_q;
  logic [63:0] dur_q, elapsed_q;
  logic [31:0] delta_q, r_q, n_q;
  logic [61:0] prod;
  logic [63:0] bps;
  logic [16:0] loss;

  logic [63:0] drem, dlo, dden, dq;

  assign idx = rem_h[SLOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (cfg_valid) begin
      interval <= cfg_data;
    end
  end

  // hash, then modulo by reciprocal multiplication over four steps
  logic [31:0]          word;
  logic [HASH_BITS-1:0] h_step;
  logic [48:0]          hp_hi, hp_lo, hp_sum;
  logic [24:0]          hq, hqm, r_est;
  logic [MOD_BITS-1:0]  rem_step;

  always_comb begin
    unique case (cmd.cnt[1:0])
      2'd0:    word = rec_q.src_ip;
      2'd1:    word = rec_q.dst_ip;
      2'd2:    word = {16'd0, rec_q.sport};
      default: word = {16'd0, rec_q.dport};
    endcase
    h_step = (h << 5) + h + HASH_BITS'(word);
    hp_sum = hp_hi + {24'd0, hp_lo[48:24]};
    // quotient estimate is exact or one low
    r_est  = h[24:0] - hqm;
    if (r_est >= {1'b0, HASH_MOD}) begin
      rem_step = MOD_BITS'(r_est - {1'b0, HASH_MOD});
    end else begin
      rem_step = r_est[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rec_q <= rec;
      h     <= HASH_SEED;
      rem_h <= '0;
    end else if (cmd.hash_step) begin
      h <= h_step;
    end else if (cmd.mod_step) begin
      unique case (cmd.cnt[1:0])
        2'd0: begin
          hp_hi <= 49'(h[47:24]) * 49'(HASH_RECIP);
          hp_lo <= 49'(h[23:0]) * 49'(HASH_RECIP);
        end
        2'd1: begin
          hq <= hp_sum[48:24];
        end
        2'd2: begin
          hqm <= hq * 25'(HASH_MOD);
        end
        default: begin
          rem_h <= rem_step;
        end
      endcase
    end
  end

  // record fields in host order
  logic [63:0] now;
  logic [31:0] kind, bmin, b0, b1, b2, b3, bm01, bm23;
  logic [15:0] pmin, p0, p1, p2, p3, pm01, pm23;

  always_comb begin
    now  = swap64(rec_q.stamp_ns);
    kind = swap32(rec_q.packet_kind);
    b0 = swap32(rec_q.byte_rows_low[31:0]);
    b1 = swap32(rec_q.byte_rows_low[63:32]);
    b2 = swap32(rec_q.byte_rows_high[31:0]);
    b3 = swap32(rec_q.byte_rows_high[63:32]);
    p0 = swap16(rec_q.packet_rows[15:0]);
    p1 = swap16(rec_q.packet_rows[31:16]);
    p2 = swap16(rec_q.packet_rows[47:32]);
    p3 = swap16(rec_q.packet_rows[63:48]);
    bm01 = (b1 < b0) ? b1 : b0;
    bm23 = (b3 < b2) ? b3 : b2;
    bmin = (bm23 < bm01) ? bm23 : bm01;
    pm01 = (p1 < p0) ? p1 : p0;
    pm23 = (p3 < p2) ? p3 : p2;
    pmin = (pm23 < pm01) ? pm23 : pm01;
  end

  // slot update
  slot_t       wr;
  logic        we, rep, fresh;
  logic [31:0] db, dpk1, ntb, nr, nn;
  logic [63:0] el;
  logic [1:0]  st;

  always_comb begin
    wr    = rd_q;
    fresh = rd_q.used && (now > rd_q.last_ns);
    db    = (bmin >= rd_q.last_byte_min) ? bmin - rd_q.last_byte_min : 32'd0;
    dpk1  = (pmin >= rd_q.last_packet_min) ?
            32'(pmin - rd_q.last_packet_min) + 32'd1 : 32'd1;
    ntb   = rd_q.total_bytes + db;
    nr    = rd_q.retransmits + ((rec_q.ack_number == rd_q.last_ack) ? 32'd1 : 32'd0);
    nn    = rd_q.interval_packets + dpk1;
    el    = now - rd_q.report_ns;
    rep   = fresh && (el >= interval);
    st    = ST_STALE;
    we    = 1'b0;
    if (!rd_q.used) begin
      st                 = ST_CREATED;
      we                 = 1'b1;
      wr.used            = 1'b1;
      wr.key             = {rec_q.src_ip, rec_q.dst_ip};
      wr.ports           = {rec_q.sport, rec_q.dport};
      wr.start_ns        = now;
      wr.last_ns         = now;
      wr.report_ns       = now;
      wr.last_byte_min   = bmin;
      wr.last_packet_min = pmin;
      wr.last_ack        = rec_q.ack_number;
      wr.total_bytes     = bmin;
      wr.total_packets   = {16'd0, pmin};
      wr.reported_bytes  = '0;
      wr.retransmits     = '0;
      wr.interval_packets = '0;
    end else if (fresh) begin
      st                 = ST_UPDATED;
      we                 = 1'b1;
      wr.total_bytes     = ntb;
      wr.total_packets   = rd_q.total_packets + dpk1;
      wr.last_byte_min   = bmin;
      wr.last_packet_min = pmin;
      wr.last_ack        = rec_q.ack_number;
      wr.last_ns         = now;
      wr.retransmits     = nr;
      wr.interval_packets = nn;
      if (rep) begin
        wr.report_ns        = now;
        wr.reported_bytes   = ntb;
        wr.retransmits      = '0;
        wr.interval_packets = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[cmd.cnt[SLOT_BITS-1:0]] <= '0;
    end else if (cmd.upd && we) begin
      mem[idx] <= wr;
    end
    if (cmd.rd) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      st_q      <= st;
      tb_q      <= wr.total_bytes;
      tp_q      <= wr.total_packets;
      rep_q     <= rep;
      end_q     <= (st == ST_UPDATED) && (kind == KIND_END);
      dur_q     <= ((st == ST_UPDATED) && (kind == KIND_END)) ? now - rd_q.start_ns : 64'd0;
      elapsed_q <= el;
      delta_q   <= ntb - rd_q.reported_bytes;
      r_q       <= nr;
      n_q       <= nn;
      bps       <= '0;
      loss      <= '0;
    end
    if (cmd.mul) begin
      prod   <= 62'(delta_q) * 62'(NS_PER_S);
      full_q <= r_q >= n_q;
    end
    if (cmd.bps_save) begin
      if ((elapsed_q == 64'd0) || ((elapsed_q == 64'd1) && prod[61])) begin
        bps <= '1;
      end else begin
        bps <= dq;
      end
    end
    if (cmd.loss_save) begin
      loss <= full_q ? LOSS_ONE : dq[16:0];
    end
  end

  // shared restoring divider, one quotient bit per cycle
  logic [64:0] dtry;

  always_comb begin
    dtry = {drem, dlo[63]};
  end

  always_ff @(posedge clk) begin
    if (cmd.bps_init) begin
      drem <= {63'd0, prod[61]};
      dlo  <= {prod[60:0], 3'd0};
      dden <= elapsed_q;
      dq   <= '0;
    end else if (cmd.loss_init) begin
      drem <= '0;
      dlo  <= {16'd0, r_q, 16'd0};
      dden <= {32'd0, n_q};
      dq   <= '0;
    end else if (cmd.div_step) begin
      dlo <= dlo << 1;
      if (dtry >= {1'b0, dden}) begin
        drem <= 64'(dtry - {1'b0, dden});
        dq   <= {dq[62:0], 1'b1};
      end else begin
        drem <= dtry[63:0];
        dq   <= {dq[62:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.status         <= st_q;
      res.slot_index     <= idx;
      res.total_bytes    <= tb_q;
      res.total_packets  <= tp_q;
      res.report_valid   <= rep_q;
      res.throughput_bps <= bps;
      res.loss_fraction  <= loss;
      res.ended          <= end_q;
      res.duration_ns    <= dur_q;
    end
  end

  assign sts.report   = rep_q;
  assign sts.full     = full_q;
  assign sts.out_free = !out_valid || out_ready;

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result not shown after load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_quiet_report: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.report_valid) |->
      (res.throughput_bps == 64'd0 && res.loss_fraction == 17'd0))
    else $error("report fields set without report");

  a_end_on_update: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.ended) |-> (res.status == ST_UPDATED))
    else $error("end flag on a non-update");

endmodule

`default_nettype wire

// File: hw/rtl/flow_record_update_engine.sv
// top level of the flow record update engine
// depends on frue_pkg, frue_ctrl and frue_dp
//
// channels: rec (in_valid/in_ready) carries one telemetry record, res
// (out_valid/out_ready) returns one result per record, cfg (cfg_valid/
// cfg_ready) writes interval_ns and is always ready.
// after reset the slot memory is swept clear, one slot a cycle, while
// in_ready stays low.
// from transfer to result one record passes through 4 hash steps, the modulo
// by reciprocal multiplication, one slot read, one update and write, one
// multiply and the load of the result register; a new record is taken only
// once the previous one has loaded its result. an interval report adds a
// setup state, a 64-step throughput pass of the shared bit-serial divider,
// a second setup, a loss pass unless the loss saturates at one, and a save.
// the result register holds a finished result while the next record is
// taken; if the receiver stalls, the following result waits in the datapath
// and then in_ready stays low until the register frees.
`default_nettype none

module flow_record_update_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire frue_pkg::rec_t rec,
  output logic                out_valid,
  input  wire logic           out_ready,
  output frue_pkg::res_t      res,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [63:0]    cfg_data
);
  import frue_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  frue_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  frue_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res)
  );

endmodule

`default_nettype wire

// File: dv/flow_record_update_engine_tb.sv
// self-checking testbench for flow_record_update_engine: records from a small flow pool plus noise,
// predicted per transfer by an in-bench slot table model, results checked in order
// depends on frue_pkg and the flow_record_update_engine rtl
`default_nettype none

module flow_record_update_engine_tb;
  import frue_pkg::*;

  localparam int FLOWS = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [63:0] HASH_START = 64'd5381;
  localparam logic [63:0] HASH_MODULUS = 64'd10485750;
  localparam logic [31:0] KIND_FIN_RST = 32'd4;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  rec_t rec;
  res_t res;
  logic [63:0] cfg_data;

  flow_record_update_engine i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rec(rec),
    .out_valid(out_valid), .out_ready(out_ready), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // flow table model
  logic [63:0] interval_reg = INTERVAL_RESET;
  bit          tbl_used [SLOTS];
  logic [63:0] tbl_start [SLOTS];
  logic [63:0] tbl_last [SLOTS];
  logic [63:0] tbl_report [SLOTS];
  logic [31:0] tbl_bmin [SLOTS];
  logic [15:0] tbl_pmin [SLOTS];
  logic [31:0] tbl_ack [SLOTS];
  logic [31:0] tbl_bytes [SLOTS];
  logic [31:0] tbl_pkts [SLOTS];
  logic [31:0] tbl_rep_bytes [SLOTS];
  logic [31:0] tbl_retx [SLOTS];
  logic [31:0] tbl_ipkts [SLOTS];

  rec_t pending_recs [$];
  res_t expected_results [$];
  int   n_accepted, n_errors, watchdog;
  int   rx_hold;
  bit   rx_held_once;

  // flow pool
  logic [31:0] fl_sip [FLOWS], fl_dip [FLOWS], fl_ack [FLOWS], fl_bmin [FLOWS];
  logic [15:0] fl_sp [FLOWS], fl_dp [FLOWS], fl_pmin [FLOWS];
  logic [63:0] fl_now [FLOWS];

  function automatic logic [31:0] bswap32(logic [31:0] x);
    return {<<8{x}};
  endfunction

  function automatic logic [15:0] bswap16(logic [15:0] x);
    return {<<8{x}};
  endfunction

  function automatic logic [63:0] bswap64(logic [63:0] x);
    return {<<8{x}};
  endfunction

  function automatic logic [31:0] min_of4(logic [31:0] a, b, c, d);
    logic [31:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    if (d < m) m = d;
    return m;
  endfunction

  function automatic logic [63:0] throughput_of(logic [31:0] delta, logic [63:0] elapsed);
    logic [127:0] num, q;
    num = 128'(delta) * 128'd8000000000;
    if (elapsed == 0) return '1;
    q = num / 128'(elapsed);
    if (q[127:64] != 0) return '1;
    return q[63:0];
  endfunction

  function automatic res_t update_flow_table(rec_t r);
    res_t o;
    logic [63:0] h, now, elapsed;
    logic [31:0] bmin, pmin, db, dpk, rx, np;
    logic [11:0] s;
    h = HASH_START;
    h = h * 33 + r.src_ip;
    h = h * 33 + r.dst_ip;
    h = h * 33 + r.sport;
    h = h * 33 + r.dport;
    s = 12'((h % HASH_MODULUS) % SLOTS);
    now = bswap64(r.stamp_ns);
    bmin = min_of4(bswap32(r.byte_rows_low[31:0]), bswap32(r.byte_rows_low[63:32]),
                   bswap32(r.byte_rows_high[31:0]), bswap32(r.byte_rows_high[63:32]));
    pmin = min_of4(32'(bswap16(r.packet_rows[15:0])), 32'(bswap16(r.packet_rows[31:16])),
                   32'(bswap16(r.packet_rows[47:32])), 32'(bswap16(r.packet_rows[63:48])));
    o = '0;
    o.status = ST_STALE;
    o.slot_index = s;
    if (!tbl_used[s]) begin
      tbl_used[s] = 1;
      tbl_start[s] = now;
      tbl_last[s] = now;
      tbl_report[s] = now;
      tbl_bmin[s] = bmin;
      tbl_pmin[s] = pmin[15:0];
      tbl_ack[s] = r.ack_number;
      tbl_bytes[s] = bmin;
      tbl_pkts[s] = pmin;
      tbl_rep_bytes[s] = 0;
      tbl_retx[s] = 0;
      tbl_ipkts[s] = 0;
      o.status = ST_CREATED;
    end else if (now > tbl_last[s]) begin
      db = (bmin >= tbl_bmin[s]) ? bmin - tbl_bmin[s] : 0;
      dpk = (pmin >= 32'(tbl_pmin[s])) ? pmin - 32'(tbl_pmin[s]) : 0;
      tbl_bytes[s] += db;
      tbl_pkts[s] += dpk + 1;
      tbl_ipkts[s] += dpk + 1;
      tbl_bmin[s] = bmin;
      tbl_pmin[s] = pmin[15:0];
      if (bswap32(r.packet_kind) == KIND_FIN_RST) begin
        o.ended = 1;
        o.duration_ns = now - tbl_start[s];
      end
      if (r.ack_number == tbl_ack[s]) tbl_retx[s] += 1;
      tbl_ack[s] = r.ack_number;
      tbl_last[s] = now;
      elapsed = now - tbl_report[s];
      if (elapsed >= interval_reg) begin
        rx = tbl_retx[s];
        np = tbl_ipkts[s];
        o.report_valid = 1;
        o.throughput_bps = throughput_of(tbl_bytes[s] - tbl_rep_bytes[s], elapsed);
        o.loss_fraction = (rx >= np) ? LOSS_ONE : 17'((64'(rx) << 16) / np);
        tbl_report[s] = now;
        tbl_rep_bytes[s] = tbl_bytes[s];
        tbl_retx[s] = 0;
        tbl_ipkts[s] = 0;
      end
      o.status = ST_UPDATED;
    end
    o.total_bytes = tbl_bytes[s];
    o.total_packets = tbl_pkts[s];
    return o;
  endfunction

  function automatic rec_t flow_record(int k);
    rec_t r;
    logic [31:0] br [4];
    logic [15:0] pk [4];
    int jb, jp;
    r.src_ip = fl_sip[k];
    r.dst_ip = fl_dip[k];
    r.sport = fl_sp[k];
    r.dport = fl_dp[k];
    if ($urandom_range(0, 99) < 8) begin
      r.stamp_ns = bswap64(fl_now[k] - $urandom_range(0, 2));
    end else begin
      if ($urandom_range(0, 3) == 0) fl_now[k] += $urandom_range(1, 1000);
      else fl_now[k] += $urandom_range(1, 700000000);
      r.stamp_ns = bswap64(fl_now[k]);
    end
    if ($urandom_range(0, 99) < 85) fl_bmin[k] += $urandom_range(0, 50000);
    else fl_bmin[k] -= $urandom_range(1, 5000);
    if ($urandom_range(0, 99) < 85) fl_pmin[k] += 16'($urandom_range(0, 60));
    else fl_pmin[k] -= 16'($urandom_range(1, 20));
    jb = $urandom_range(0, 3);
    jp = $urandom_range(0, 3);
    for (int j = 0; j < 4; j++) begin
      br[j] = (j == jb) ? fl_bmin[k] : fl_bmin[k] + $urandom_range(0, 1000);
      pk[j] = (j == jp) ? fl_pmin[k] : fl_pmin[k] + 16'($urandom_range(0, 30));
    end
    r.byte_rows_low = {bswap32(br[1]), bswap32(br[0])};
    r.byte_rows_high = {bswap32(br[3]), bswap32(br[2])};
    r.packet_rows = {bswap16(pk[3]), bswap16(pk[2]), bswap16(pk[1]), bswap16(pk[0])};
    if ($urandom_range(0, 99) >= 30) fl_ack[k] = $urandom;
    r.ack_number = fl_ack[k];
    r.packet_kind = ($urandom_range(0, 9) == 0) ? bswap32(KIND_FIN_RST)
                                                : bswap32($urandom_range(0, 8));
    return r;
  endfunction

  function automatic rec_t noise_record();
    rec_t r;
    r.src_ip = $urandom;
    r.dst_ip = $urandom;
    r.sport = 16'($urandom);
    r.dport = 16'($urandom);
    r.stamp_ns = {$urandom, $urandom};
    r.byte_rows_low = {$urandom, $urandom};
    r.byte_rows_high = {$urandom, $urandom};
    r.packet_rows = {$urandom, $urandom};
    r.ack_number = $urandom;
    r.packet_kind = $urandom;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // record driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (pending_recs.size() > 0 &&
          ((n_accepted >= 100 && n_accepted < 180) || $urandom_range(0, 99) >= 26)) begin
        in_valid <= 1;
        rec <= pending_recs.pop_front();
      end else begin
        in_valid <= 0;
      end
    end
  end

  // result receiver, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      rx_hold <= 0;
      rx_held_once <= 0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 0;
    end else if (!rx_held_once && n_accepted >= 230) begin
      rx_hold <= 500;
      rx_held_once <= 1;
      out_ready <= 0;
    end else begin
      out_ready <= (n_accepted >= 300 && n_accepted < 380) || $urandom_range(0, 99) >= 26;
    end
  end

  // prediction on each input transfer and register write
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      expected_results.push_back(update_flow_table(rec));
      n_accepted <= n_accepted + 1;
    end
    if (!rst && cfg_valid && cfg_ready) interval_reg = cfg_data;
  end

  // result checker
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %p", res);
      end else begin
        exp_res = expected_results.pop_front();
        if (res.status !== exp_res.status || res.slot_index !== exp_res.slot_index ||
            res.total_bytes !== exp_res.total_bytes ||
            res.total_packets !== exp_res.total_packets ||
            res.report_valid !== exp_res.report_valid ||
            res.throughput_bps !== exp_res.throughput_bps ||
            res.loss_fraction !== exp_res.loss_fraction || res.ended !== exp_res.ended ||
            res.duration_ns !== exp_res.duration_ns) begin
          n_errors++;
          if (n_errors <= 10) $display("result differs: expected %p actual %p", exp_res, res);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      watchdog <= 0;
    end else if (watchdog >= WATCHDOG_LIMIT) begin
      $display("flow_record_update_engine: mismatch");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  initial begin
    logic [63:0] intervals [6];
    rec_t r;
    intervals = '{64'd0, 64'd1, 64'd40000000, '1, 64'd1000000000, 64'd300000000};
    rst = 1;
    in_valid = 0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_data = '0;
    rec = '0;
    n_accepted = 0;
    n_errors = 0;
    watchdog = 0;
    for (int k = 0; k < FLOWS; k++) begin
      fl_sip[k] = $urandom;
      fl_dip[k] = $urandom;
      fl_sp[k] = 16'($urandom);
      fl_dp[k] = 16'($urandom);
      fl_now[k] = {$urandom_range(0, 15), $urandom};
      fl_bmin[k] = $urandom_range(0, 100000);
      fl_pmin[k] = 16'($urandom_range(0, 1000));
      fl_ack[k] = $urandom;
    end
    repeat (2) @(posedge clk);
    rst <= 0;

    // extremes, end of flow, stale, repeated ack
    pending_recs.push_back('0);
    pending_recs.push_back('1);
    r = '1;
    r.stamp_ns = '0;
    pending_recs.push_back(r);
    r = '0;
    r.stamp_ns = bswap64(64'd5);
    r.packet_kind = bswap32(KIND_FIN_RST);
    pending_recs.push_back(r);
    for (int i = 0; i < 16; i++) pending_recs.push_back(flow_record(i % 4));

    for (int p = 0; p <= 6; p++) begin
      if (p > 0) begin
        cfg_valid <= 1;
        cfg_data <= intervals[p-1];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
      end
      for (int i = 0; i < 64; i++) begin
        if ($urandom_range(0, 99) < 15) pending_recs.push_back(noise_record());
        else pending_recs.push_back(flow_record($urandom_range(0, FLOWS - 1)));
      end
      while (pending_recs.size() > 0 || in_valid || expected_results.size() > 0)
        @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("flow_record_update_engine: match");
    end else begin
      $display("flow_record_update_engine: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: flow_record_update_engine.f
hw/rtl/frue_pkg.sv
hw/rtl/frue_ctrl.sv
hw/rtl/frue_dp.sv
hw/rtl/flow_record_update_engine.sv
dv/flow_record_update_engine_tb.sv
